>>> sv/tptu_pkg.sv
// ----------------------------------------------------------------------------
// tptu_pkg: shared constants for the two-level page table updater
// Opcodes, status codes, entry attribute bits, pool defaults and fixed field widths.
// ----------------------------------------------------------------------------
package tptu_pkg;

  // field widths
  localparam int PAGE_W = 20;
  localparam int ATTR_W = 12;
  localparam int IDX_W  = 10;
  localparam int ENTRY_W = 32;

  // pool defaults
  localparam int POOL_FRAMES_DEF = 64;
  localparam logic [PAGE_W-1:0] POOL_BASE_RST = 20'd256;

  // opcodes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_MAP   = 2'd1;
  localparam logic [1:0] OP_UNMAP = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ABSENT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_OUTSIDE = 2'd3;

  // attribute bits
  localparam logic [ATTR_W-1:0] ATTR_P = 12'h001;
  localparam logic [ATTR_W-1:0] ATTR_WR = 12'h002;
  localparam logic [ATTR_W-1:0] ATTR_U = 12'h004;

endpackage

>>> sv/tptu_mem.sv
// ----------------------------------------------------------------------------
// tptu_mem: frame store
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module tptu_mem #(
  parameter int AW = 16
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic [tptu_pkg::ENTRY_W-1:0]    wdata,
  input  logic                            re,
  input  logic [AW-1:0]                   raddr,
  output logic [tptu_pkg::ENTRY_W-1:0]    rdata
);

  logic [tptu_pkg::ENTRY_W-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/tptu_ctrl.sv
// ----------------------------------------------------------------------------
// tptu_ctrl: operation sequencer
// Walks directory and table entries in the frame store, runs the bump
// allocator and its clearing sweep, and holds the pool base register.
// ----------------------------------------------------------------------------
module tptu_ctrl #(
  parameter int POOL_FRAMES = tptu_pkg::POOL_FRAMES_DEF,
  parameter int FIW = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1,
  parameter int AW  = FIW + tptu_pkg::IDX_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tptu_pkg::PAGE_W-1:0]    cfg_wdata,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     opcode,
  input  logic [tptu_pkg::PAGE_W-1:0]    dir_page,
  input  logic [tptu_pkg::PAGE_W-1:0]    virt_page,
  input  logic [tptu_pkg::PAGE_W-1:0]    map_page,
  input  logic [tptu_pkg::ATTR_W-1:0]    attrs,
  output logic                           done,
  output logic [tptu_pkg::PAGE_W-1:0]    result_page,
  output logic [1:0]                     status,
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output logic [tptu_pkg::ENTRY_W-1:0]   mem_wdata,
  output logic                           mem_re,
  output logic [AW-1:0]                  mem_raddr,
  input  logic [tptu_pkg::ENTRY_W-1:0]   mem_rdata
);

  localparam int CW = $clog2(POOL_FRAMES + 1);
  localparam int PW = tptu_pkg::PAGE_W;
  localparam int XW = tptu_pkg::IDX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIR   = 3'd1;
  localparam logic [2:0] S_PDE   = 3'd2;
  localparam logic [2:0] S_PTE   = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam logic [2:0] S_LINK  = 3'd5;
  localparam logic [2:0] S_FILL  = 3'd6;

  logic [2:0]    state, state_next;
  logic [PW-1:0] pool_base;
  logic [CW-1:0] nff, nff_next;
  logic [XW-1:0] clr_cnt, clr_cnt_next;
  logic [1:0]    op_r;
  logic [PW-1:0] dir_r, vp_r, pp_r;
  logic [tptu_pkg::ATTR_W-1:0] at_r;
  logic [FIW-1:0] dframe, dframe_next;
  logic [FIW-1:0] tframe, tframe_next;
  logic          done_next;
  logic [PW-1:0] res_next;
  logic [1:0]    st_next;

  logic [PW-1:0] dir_off, tbl_off, new_page;
  logic          dir_in, tbl_in, full;
  logic [XW-1:0] di, ti;
  logic [tptu_pkg::ENTRY_W-1:0] pte, pde_new;

  // pool base register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= tptu_pkg::POOL_BASE_RST;
    end else if (cfg_we) begin
      pool_base <= cfg_wdata;
    end
  end

  // pointer checks and entry images
  assign di       = vp_r[PW-1:XW];
  assign ti       = vp_r[XW-1:0];
  assign full     = (nff == CW'(POOL_FRAMES));
  assign dir_off  = dir_r - pool_base;
  assign tbl_off  = mem_rdata[tptu_pkg::ENTRY_W-1:tptu_pkg::ATTR_W] - pool_base;
  assign dir_in   = (dir_off < {{(PW-CW){1'b0}}, nff});
  assign tbl_in   = (tbl_off < {{(PW-CW){1'b0}}, nff});
  assign new_page = pool_base + {{(PW-CW){1'b0}}, nff};
  assign pte      = {pp_r, at_r | tptu_pkg::ATTR_P};
  assign pde_new  = {new_page, tptu_pkg::ATTR_P | tptu_pkg::ATTR_WR | (at_r & tptu_pkg::ATTR_U)};
  assign busy     = (state != S_IDLE);

  // sequencer
  always_comb begin
    state_next   = state;
    nff_next     = nff;
    clr_cnt_next = clr_cnt;
    dframe_next  = dframe;
    tframe_next  = tframe;
    done_next    = 1'b0;
    res_next     = result_page;
    st_next      = status;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DIR;
        end
      end
      S_DIR: begin
        if (op_r == tptu_pkg::OP_ALLOC) begin
          if (full) begin
            done_next = 1'b1; res_next = '0; st_next = tptu_pkg::ST_FULL;
            state_next = S_IDLE;
          end else begin
            clr_cnt_next = '0;
            state_next = S_CLEAR;
          end
        end else if (op_r == tptu_pkg::OP_NONE) begin
          done_next = 1'b1; res_next = '0; st_next = tptu_pkg::ST_OK;
          state_next = S_IDLE;
        end else if (!dir_in) begin
          done_next = 1'b1; res_next = '0; st_next = tptu_pkg::ST_OUTSIDE;
          state_next = S_IDLE;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = {dir_off[FIW-1:0], di};
          dframe_next = dir_off[FIW-1:0];
          state_next  = S_PDE;
        end
      end
      S_PDE: begin
        if (mem_rdata[0] == 1'b0) begin
          if (op_r == tptu_pkg::OP_UNMAP) begin
            done_next = 1'b1; res_next = '0; st_next = tptu_pkg::ST_ABSENT;
            state_next = S_IDLE;
          end else if (full) begin
            done_next = 1'b1; res_next = '0; st_next = tptu_pkg::ST_FULL;
            state_next = S_IDLE;
          end else begin
            clr_cnt_next = '0;
            state_next = S_CLEAR;
          end
        end else if (!tbl_in) begin
          done_next = 1'b1; res_next = '0; st_next = tptu_pkg::ST_OUTSIDE;
          state_next = S_IDLE;
        end else if (op_r == tptu_pkg::OP_MAP) begin
          mem_we    = 1'b1;
          mem_waddr = {tbl_off[FIW-1:0], ti};
          mem_wdata = pte;
          done_next = 1'b1; res_next = '0; st_next = tptu_pkg::ST_OK;
          state_next = S_IDLE;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = {tbl_off[FIW-1:0], ti};
          tframe_next = tbl_off[FIW-1:0];
          state_next  = S_PTE;
        end
      end
      S_PTE: begin
        // unmap: return old frame number and clear the entry
        mem_we    = 1'b1;
        mem_waddr = {tframe, ti};
        mem_wdata = '0;
        done_next = 1'b1;
        res_next  = mem_rdata[tptu_pkg::ENTRY_W-1:tptu_pkg::ATTR_W];
        st_next   = tptu_pkg::ST_OK;
        state_next = S_IDLE;
      end
      S_CLEAR: begin
        // zero-fill the frame being handed out, one entry a cycle
        mem_we       = 1'b1;
        mem_waddr    = {nff[FIW-1:0], clr_cnt};
        mem_wdata    = '0;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == {XW{1'b1}}) begin
          if (op_r == tptu_pkg::OP_ALLOC) begin
            nff_next  = nff + 1'b1;
            done_next = 1'b1; res_next = new_page; st_next = tptu_pkg::ST_OK;
            state_next = S_IDLE;
          end else begin
            state_next = S_LINK;
          end
        end
      end
      S_LINK: begin
        mem_we     = 1'b1;
        mem_waddr  = {dframe, di};
        mem_wdata  = pde_new;
        state_next = S_FILL;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = {nff[FIW-1:0], ti};
        mem_wdata = pte;
        nff_next  = nff + 1'b1;
        done_next = 1'b1; res_next = '0; st_next = tptu_pkg::ST_OK;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nff   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      nff   <= nff_next;
      done  <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    clr_cnt     <= clr_cnt_next;
    dframe      <= dframe_next;
    tframe      <= tframe_next;
    result_page <= res_next;
    status      <= st_next;
    if (state == S_IDLE && start) begin
      op_r  <= opcode;
      dir_r <= dir_page;
      vp_r  <= virt_page;
      pp_r  <= map_page;
      at_r  <= attrs;
    end
  end

endmodule

>>> sv/two_level_page_table_updater_top.sv
// ----------------------------------------------------------------------------
// two_level_page_table_updater_top: two-level page table map/unmap engine
// Keeps x86-style page directories and tables in a pool of frames.
// ----------------------------------------------------------------------------
// usage
//   a command word (opcode, dir_page, virt_page, map_page, attrs) is taken
//   at a rising edge with start high and busy low. busy stays high until the
//   command is finished; done then pulses for one cycle with result_page and
//   status valid in that cycle. the receiver cannot stall; results must be
//   taken when done is high. a new command may be issued in the done cycle.
//   pool_base is written through cfg_we / cfg_wdata; write it only while idle, the block does not enforce this.
// steps
//   every command starts with a check step, then walks the frame store:
//     unused opcode, early failure: check step only
//     map into a present table: directory read, then table entry write
//     unmap: directory read, table entry read, then entry clear
//     allocate: clearing sweep; map needing a new table: directory read,
//     clearing sweep, directory link, table entry write; the sweep clears one entry per cycle.
// reset
//   synchronous rst empties the pool (no frames allocated) and sets the
//   pool base to 256; frame contents are not cleared, as frames are only
//   readable after allocation has zero-filled them.
// ----------------------------------------------------------------------------
module two_level_page_table_updater_top #(
  parameter int POOL_FRAMES = tptu_pkg::POOL_FRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tptu_pkg::PAGE_W-1:0]    cfg_wdata,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     opcode,
  input  logic [tptu_pkg::PAGE_W-1:0]    dir_page,
  input  logic [tptu_pkg::PAGE_W-1:0]    virt_page,
  input  logic [tptu_pkg::PAGE_W-1:0]    map_page,
  input  logic [tptu_pkg::ATTR_W-1:0]    attrs,
  output logic                           done,
  output logic [tptu_pkg::PAGE_W-1:0]    result_page,
  output logic [1:0]                     status
);

  localparam int FIW = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
  localparam int AW  = FIW + tptu_pkg::IDX_W;

  logic                         mem_we, mem_re;
  logic [AW-1:0]                mem_waddr, mem_raddr;
  logic [tptu_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;

  // sequencer
  tptu_ctrl #(
    .POOL_FRAMES (POOL_FRAMES),
    .FIW         (FIW),
    .AW          (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .dir_page    (dir_page),
    .virt_page   (virt_page),
    .map_page    (map_page),
    .attrs       (attrs),
    .done        (done),
    .result_page (result_page),
    .status      (status),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  // frame store
  tptu_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

>>> sv/tptu_checker.sv
// ----------------------------------------------------------------------------
// tptu_checker: port-level checks for the page table updater
// Watches the command and result ports; bound to the top level.
// ----------------------------------------------------------------------------
module tptu_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [tptu_pkg::PAGE_W-1:0] result_page,
  input logic [1:0]                  status
);

  // an accepted command makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // a result ends a busy period
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("done outside the end of a command");

  // failed operations report page 0
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != tptu_pkg::ST_OK) |-> (result_page == '0))
    else $error("failed operation returned a page");

  // one result per command
  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back result strobes");

endmodule

bind two_level_page_table_updater_top tptu_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .result_page (result_page),
  .status      (status)
);
